@@ sv/gcdb_pkg.sv @@
package gcdb_pkg;

	localparam int XY_W   = 36;
	localparam int Z_W    = 34;
	localparam int OP_W   = 34;
	localparam int PROD_W = 2 * OP_W;

	localparam logic signed [XY_W-1:0] INV_GAIN     = 36'sd652032874;
	localparam logic signed [Z_W-1:0]  QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [Z_W-1:0]  HALF_TURN    = 34'sd2147483648;
	localparam logic signed [Z_W-1:0]  FULL_TURN    = 34'sd4294967296;

	localparam logic [9:0] DEG_PER_TURN  = 10'd360;
	localparam logic [8:0] DEG_ROUND     = 9'd180;

	localparam logic [63:0] EARTH_RADIUS_M = 64'd6372795;
	localparam logic [63:0] PI_Q30         = 64'd3373259426;
	localparam logic [31:0] DIST_SCALE     = 32'((EARTH_RADIUS_M * PI_Q30) >> 23);
	localparam logic [24:0] DIST_MAX       = 25'h1FFFFFF;

	typedef struct packed {
		logic signed [30:0] new_lat;
		logic signed [31:0] new_lon;
	} fix_t;

	typedef struct packed {
		logic [24:0] distance_m;
		logic [8:0]  bearing_deg;
	} result_t;

	typedef struct packed {
		logic                   start;
		logic                   vector;
		logic [31:0]            phase;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
	} cordic_req_t;

	// atan(2^-i) as binary angle, 2^32 per turn
	function automatic logic [31:0] atan_unit(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			5'd30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

@@ sv/great_circle_distance_bearing.sv @@
// Great-circle distance and initial bearing between consecutive position fixes.
// fix channel: one transaction per fix (new_lat, new_lon, degrees * 2^FRAC).
// result channel: one transaction per fix, distance from the previous fix in
// metres and bearing in whole degrees 0..359.
// fix_stall is high from acceptance until the result has been moved to the
// output register; one fix is processed at a time.
// From the fix transaction to result_valid the block runs three angle
// conversions (reciprocal multiply over four partial products), five CORDIC
// passes, a 32-step square root, eleven products on one multiplier and a
// load of the output register.
// A finished result waits in the output register while result_stall is high;
// the next fix is already taken and processed meanwhile, and only its own
// delivery waits for the register to drain.
// Reset clears the kept fix to 0,0 and empties the output register.
module great_circle_distance_bearing #(
	parameter int ANGLE_FRAC_BITS = 23,
	parameter int CORDIC_STEPS    = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fix_valid,
	output logic              fix_stall,
	input  gcdb_pkg::fix_t    fix,
	output logic              result_valid,
	input  logic              result_stall,
	output gcdb_pkg::result_t result
);

	localparam int OW = gcdb_pkg::OP_W;
	localparam int PW = gcdb_pkg::PROD_W;
	localparam int XW = gcdb_pkg::XY_W;
	localparam int ZW = gcdb_pkg::Z_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PHASE, ST_ROT, ST_MUL, ST_TAKE,
		ST_SQRT, ST_VEC_TH, ST_VEC_B, ST_DONE
	} state_t;

	typedef enum logic [1:0] {TR_DLON, TR_LAT1, TR_LAT2} trig_t;

	typedef enum logic [3:0] {
		MS_C1S2, MS_S1C2, MS_T2CD_X, MS_SDC2, MS_S1S2, MS_C1C2,
		MS_T2CD_D, MS_XX, MS_YY, MS_DIST, MS_BEAR
	} mul_step_t;

	state_t    state_q;
	trig_t     trig_q;
	mul_step_t step_q;

	logic signed [30:0] prev_lat_q, lat1_q, lat2_q;
	logic signed [31:0] prev_lon_q;
	logic signed [32:0] dlon_q;

	logic signed [OW-1:0] sd_q, cd_q, s1_q, c1_q, s2_q, c2_q;
	logic signed [OW-1:0] t1_q, t2_q, x_q, y_q, d_q;
	logic [63:0]          acc_q;
	logic signed [ZW-1:0] theta_q, bang_q;
	logic signed [PW-1:0] prod_q;
	logic [24:0]          dist_q;
	logic [8:0]           bear_q;

	logic                  ph_start_q;
	gcdb_pkg::cordic_req_t cr_q;
	logic                  sq_start_q;

	logic                  result_valid_q;
	gcdb_pkg::result_t     result_q;

	logic                 accept;
	logic signed [32:0]   ph_d;
	logic                 ph_done;
	logic [31:0]          ph_phase;
	logic                 cr_done;
	logic signed [XW-1:0] cr_sin, cr_cos;
	logic signed [ZW-1:0] cr_angle;
	logic                 sq_done;
	logic [31:0]          sq_root;

	logic signed [OW-1:0] mul_a, mul_b;
	logic signed [OW-1:0] psh;
	logic [31:0]          theta_c;
	logic [31:0]          bang_mag;
	logic signed [ZW-1:0] bang_wrap;
	logic [25:0]          dist_raw;
	logic [8:0]           bear_m;

	assign accept    = fix_valid && !fix_stall;
	assign fix_stall = (state_q != ST_IDLE);

	always_comb begin
		case (trig_q)
			TR_DLON: ph_d = dlon_q;
			TR_LAT1: ph_d = {{2{lat1_q[30]}}, lat1_q};
			TR_LAT2: ph_d = {{2{lat2_q[30]}}, lat2_q};
			default: ph_d = '0;
		endcase
	end

	gcdb_phase #(.FRAC(ANGLE_FRAC_BITS)) u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ph_start_q),
		.d      (ph_d),
		.done   (ph_done),
		.phase  (ph_phase)
	);

	gcdb_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cr_q),
		.done   (cr_done),
		.sine   (cr_sin),
		.cosine (cr_cos),
		.angle  (cr_angle)
	);

	gcdb_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.n      (acc_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// distance angle clamped to [0, half turn]
	always_comb begin
		if (theta_q < 0)
			theta_c = '0;
		else if (theta_q > gcdb_pkg::HALF_TURN)
			theta_c = 32'h80000000;
		else
			theta_c = theta_q[31:0];
	end

	assign bang_mag = bang_q < 0 ? 32'(-bang_q) : bang_q[31:0];

	always_comb begin
		if (cr_angle > gcdb_pkg::HALF_TURN)
			bang_wrap = cr_angle - gcdb_pkg::FULL_TURN;
		else if (cr_angle < -gcdb_pkg::HALF_TURN)
			bang_wrap = cr_angle + gcdb_pkg::FULL_TURN;
		else
			bang_wrap = cr_angle;
	end

	always_comb begin
		case (step_q)
			MS_C1S2:   begin mul_a = c1_q; mul_b = s2_q; end
			MS_S1C2:   begin mul_a = s1_q; mul_b = c2_q; end
			MS_T2CD_X: begin mul_a = t2_q; mul_b = cd_q; end
			MS_SDC2:   begin mul_a = sd_q; mul_b = c2_q; end
			MS_S1S2:   begin mul_a = s1_q; mul_b = s2_q; end
			MS_C1C2:   begin mul_a = c1_q; mul_b = c2_q; end
			MS_T2CD_D: begin mul_a = t2_q; mul_b = cd_q; end
			MS_XX:     begin mul_a = x_q;  mul_b = x_q;  end
			MS_YY:     begin mul_a = y_q;  mul_b = y_q;  end
			MS_DIST: begin
				mul_a = {{(OW-32){1'b0}}, theta_c};
				mul_b = {{(OW-32){1'b0}}, gcdb_pkg::DIST_SCALE};
			end
			MS_BEAR: begin
				mul_a = {{(OW-32){1'b0}}, bang_mag};
				mul_b = {{(OW-10){1'b0}}, gcdb_pkg::DEG_PER_TURN};
			end
			default:   begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Q30 * Q30 back to Q30, floor
	assign psh      = OW'(prod_q >>> 30);
	assign dist_raw = prod_q[63:38];
	assign bear_m   = prod_q[40:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			trig_q         <= TR_DLON;
			step_q         <= MS_C1S2;
			prev_lat_q     <= '0;
			prev_lon_q     <= '0;
			ph_start_q     <= 1'b0;
			cr_q           <= '0;
			sq_start_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			ph_start_q <= 1'b0;
			cr_q.start <= 1'b0;
			sq_start_q <= 1'b0;
			if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lat1_q     <= prev_lat_q;
						lat2_q     <= fix.new_lat;
						dlon_q     <= {prev_lon_q[31], prev_lon_q}
							- {fix.new_lon[31], fix.new_lon};
						prev_lat_q <= fix.new_lat;
						prev_lon_q <= fix.new_lon;
						trig_q     <= TR_DLON;
						ph_start_q <= 1'b1;
						state_q    <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					if (ph_done) begin
						cr_q.start  <= 1'b1;
						cr_q.vector <= 1'b0;
						cr_q.phase  <= ph_phase;
						state_q     <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (cr_done) begin
						case (trig_q)
							TR_DLON: begin
								sd_q   <= OW'(cr_sin);
								cd_q   <= OW'(cr_cos);
								trig_q <= TR_LAT1;
							end
							TR_LAT1: begin
								s1_q   <= OW'(cr_sin);
								c1_q   <= OW'(cr_cos);
								trig_q <= TR_LAT2;
							end
							default: begin
								s2_q <= OW'(cr_sin);
								c2_q <= OW'(cr_cos);
							end
						endcase
						if (trig_q == TR_LAT2) begin
							step_q  <= MS_C1S2;
							state_q <= ST_MUL;
						end else begin
							ph_start_q <= 1'b1;
							state_q    <= ST_PHASE;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= ST_TAKE;
				end
				ST_TAKE: begin
					state_q <= ST_MUL;
					case (step_q)
						MS_C1S2:   begin t1_q <= psh; step_q <= MS_S1C2; end
						MS_S1C2:   begin t2_q <= psh; step_q <= MS_T2CD_X; end
						MS_T2CD_X: begin x_q <= t1_q - psh; step_q <= MS_SDC2; end
						MS_SDC2:   begin y_q <= psh; step_q <= MS_S1S2; end
						MS_S1S2:   begin t1_q <= psh; step_q <= MS_C1C2; end
						MS_C1C2:   begin t2_q <= psh; step_q <= MS_T2CD_D; end
						MS_T2CD_D: begin d_q <= t1_q + psh; step_q <= MS_XX; end
						MS_XX:     begin acc_q <= prod_q[63:0]; step_q <= MS_YY; end
						MS_YY: begin
							acc_q      <= acc_q + prod_q[63:0];
							sq_start_q <= 1'b1;
							state_q    <= ST_SQRT;
						end
						MS_DIST: begin
							dist_q <= (dist_raw > {1'b0, gcdb_pkg::DIST_MAX})
								? gcdb_pkg::DIST_MAX : dist_raw[24:0];
							step_q <= MS_BEAR;
						end
						default: begin
							// a positive angle maps to 360 - m, except m = 0
							if (bang_q > 0 && bear_m != 9'd0)
								bear_q <= 9'(gcdb_pkg::DEG_PER_TURN - {1'b0, bear_m});
							else if (bang_q > 0)
								bear_q <= '0;
							else
								bear_q <= bear_m;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_SQRT: begin
					if (sq_done) begin
						cr_q.start  <= 1'b1;
						cr_q.vector <= 1'b1;
						cr_q.x      <= {{(XW-OW){d_q[OW-1]}}, d_q};
						cr_q.y      <= {{(XW-32){1'b0}}, sq_root};
						state_q     <= ST_VEC_TH;
					end
				end
				ST_VEC_TH: begin
					if (cr_done) begin
						theta_q     <= cr_angle;
						cr_q.start  <= 1'b1;
						cr_q.vector <= 1'b1;
						cr_q.x      <= {{(XW-OW){x_q[OW-1]}}, x_q};
						cr_q.y      <= {{(XW-OW){y_q[OW-1]}}, y_q};
						state_q     <= ST_VEC_B;
					end
				end
				ST_VEC_B: begin
					if (cr_done) begin
						bang_q  <= bang_wrap;
						step_q  <= MS_DIST;
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!result_valid_q || !result_stall)) begin
			result_q.distance_m  <= dist_q;
			result_q.bearing_deg <= bear_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> fix_stall)
		else $error("block not busy after fix transaction");

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.bearing_deg < 9'd360)
		else $error("bearing out of range");

	a_distance_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.distance_m <= 25'(gcdb_pkg::DIST_SCALE >> 7))
		else $error("distance beyond half circumference");

	a_cordic_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cr_done |-> (state_q == ST_ROT || state_q == ST_VEC_TH || state_q == ST_VEC_B))
		else $error("CORDIC finished outside a waiting state");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !result_stall) |=> result_valid && !fix_stall)
		else $error("finished result not moved to output register");
`endif

endmodule

@@ sv/gcdb_phase.sv @@
// degrees * 2^FRAC to binary angle, rounded: shift right by 3, then a reciprocal
// multiply by 1/45 built from four 32 x 32 partial products on one multiplier
module gcdb_phase #(
	parameter int FRAC = 23
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] d,
	output logic               done,
	output logic [31:0]        phase
);

	// (mag << (32 - FRAC)) + 180 stays below 2^(64 - FRAC), so N >> 3 fits AW bits
	localparam int AW = 61 - FRAC;
	localparam int SH = AW + 6;
	localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'd44) / 64'd45;

	logic [63:0]  a_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic         neg_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [31:0]  phase_q;

	logic [32:0]  mag;
	logic [63:0]  num;
	logic [31:0]  op_a, op_b;
	logic [127:0] pp_sh;
	logic [127:0] acc_next;
	logic [31:0]  quo;

	assign mag      = d[32] ? (~d + 33'd1) : d;
	assign num      = ({31'd0, mag} << (32 - FRAC)) + {55'd0, gcdb_pkg::DEG_ROUND};
	assign acc_next = acc_q + pp_sh;
	assign quo      = acc_next[SH +: 32];

	// partial product issued at each count
	always_comb begin
		case (cnt_q)
			3'd0:    begin op_a = a_q[31:0];  op_b = RECIP[31:0];  end
			3'd1:    begin op_a = a_q[31:0];  op_b = RECIP[63:32]; end
			3'd2:    begin op_a = a_q[63:32]; op_b = RECIP[31:0];  end
			default: begin op_a = a_q[63:32]; op_b = RECIP[63:32]; end
		endcase
	end

	// weight of the product issued at the previous count
	always_comb begin
		case (cnt_q)
			3'd1:    pp_sh = {64'd0, pp_q};
			3'd2,
			3'd3:    pp_sh = {32'd0, pp_q, 32'd0};
			default: pp_sh = {pp_q, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= {3'd0, num[63:3]};
			acc_q <= '0;
			neg_q <= d[32];
		end else if (busy_q) begin
			pp_q <= op_a * op_b;
			if (cnt_q != 3'd0)
				acc_q <= acc_next;
			if (cnt_q == 3'd4)
				phase_q <= neg_q ? (32'd0 - quo) : quo;
		end
	end

	assign done  = done_q;
	assign phase = phase_q;

endmodule

@@ sv/gcdb_cordic.sv @@
// shared CORDIC: rotation (sin/cos of a binary angle) or vectoring (atan2)
module gcdb_cordic #(
	parameter int STEPS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gcdb_pkg::cordic_req_t           req,
	output logic                            done,
	output logic signed [gcdb_pkg::XY_W-1:0] sine,
	output logic signed [gcdb_pkg::XY_W-1:0] cosine,
	output logic signed [gcdb_pkg::Z_W-1:0]  angle
);

	localparam int XW = gcdb_pkg::XY_W;
	localparam int ZW = gcdb_pkg::Z_W;
	localparam int CW = $clog2(STEPS + 1);

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic                 vec_q, flip_q, zero_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q;

	logic [4:0]           idx;
	logic signed [XW-1:0] dx, dy;
	logic signed [ZW-1:0] a;
	logic                 sel;
	logic signed [ZW-1:0] zs;

	assign idx = cnt_q[4:0];
	assign dx  = y_q >>> idx;
	assign dy  = x_q >>> idx;
	assign a   = {{(ZW-32){1'b0}}, gcdb_pkg::atan_unit(idx)};
	assign sel = vec_q ? (y_q <= 0) : (z_q >= 0);
	assign zs  = {{(ZW-32){req.phase[31]}}, req.phase};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			vec_q  <= req.vector;
			flip_q <= 1'b0;
			zero_q <= 1'b0;
			if (!req.vector) begin
				x_q <= gcdb_pkg::INV_GAIN;
				y_q <= '0;
				// fold into +-quarter turn, negate result afterwards
				if (zs > gcdb_pkg::QUARTER_TURN) begin
					z_q    <= zs - gcdb_pkg::HALF_TURN;
					flip_q <= 1'b1;
				end else if (zs < -gcdb_pkg::QUARTER_TURN) begin
					z_q    <= zs + gcdb_pkg::HALF_TURN;
					flip_q <= 1'b1;
				end else begin
					z_q <= zs;
				end
			end else begin
				zero_q <= (req.x == 0) && (req.y == 0);
				if (req.x < 0 && req.y >= 0) begin
					x_q <= req.y;
					y_q <= -req.x;
					z_q <= gcdb_pkg::QUARTER_TURN;
				end else if (req.x < 0) begin
					x_q <= -req.y;
					y_q <= req.x;
					z_q <= -gcdb_pkg::QUARTER_TURN;
				end else begin
					x_q <= req.x;
					y_q <= req.y;
					z_q <= '0;
				end
			end
		end else if (busy_q) begin
			if (sel) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + a;
			end
		end
	end

	assign done   = done_q;
	assign sine   = flip_q ? -y_q : y_q;
	assign cosine = flip_q ? -x_q : x_q;
	assign angle  = zero_q ? '0 : z_q;

endmodule

@@ sv/gcdb_isqrt.sv @@
// floor square root, two radicand bits per cycle
module gcdb_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] n_q, r_q, bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [63:0] sum;

	assign sum = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			r_q   <= '0;
			bit_q <= 64'h4000000000000000;
		end else if (busy_q) begin
			if (n_q >= sum) begin
				n_q <= n_q - sum;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule
